### rtl/neu8_pkg.sv
// Shared types, constants and encoding functions for the numeric entity to UTF-8 block.
package neu8_pkg;

    // Job queue depth and pointer width
    localparam int NEU8_QDEPTH = 4;
    localparam int NEU8_QPTR_W = $clog2(NEU8_QDEPTH);

    // Character and code point constants
    localparam logic [7:0]  CH_HASH    = 8'h23;
    localparam logic [7:0]  CH_LOWER_X = 8'h78;
    localparam logic [7:0]  CH_UPPER_X = 8'h58;
    localparam logic [7:0]  CH_ZERO    = 8'h30;
    localparam logic [7:0]  CH_NINE    = 8'h39;
    localparam logic [7:0]  CH_UPPER_A = 8'h41;
    localparam logic [7:0]  CH_UPPER_Z = 8'h5a;
    localparam logic [31:0] CP_MAX_1B  = 32'h0000_007f;
    localparam logic [31:0] CP_MAX_2B  = 32'h0000_07ff;
    localparam logic [31:0] CP_MAX_3B  = 32'h0000_ffff;
    localparam logic [31:0] CP_MAX     = 32'h0010_ffff;
    localparam logic [7:0]  LEAD_2B    = 8'hc0;
    localparam logic [7:0]  LEAD_3B    = 8'he0;
    localparam logic [7:0]  LEAD_4B    = 8'hf0;
    localparam logic [7:0]  CONT_BYTE  = 8'h80;
    localparam logic [7:0]  REPL_B0    = 8'hef;
    localparam logic [7:0]  REPL_B1    = 8'hbf;
    localparam logic [7:0]  REPL_B2    = 8'hbd;

    // Input beat
    typedef struct packed {
        logic [7:0] token_byte;
        logic       token_end;
    } t_in;

    // Output beat
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_end;
    } t_out;

    // One queued job: up to four bytes, first in bytes[0], last index in last_idx
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
    } t_job;

    // Lax hex digit value, wrapping mod 2^32
    function automatic logic [31:0] hex_digit(input logic [7:0] b);
        logic [31:0] w;
        w = {24'd0, b};
        if (b >= CH_ZERO && b <= CH_NINE) begin
            return w - 32'h30;
        end else if (b >= CH_UPPER_A && b <= CH_UPPER_Z) begin
            return w - 32'h37;
        end else begin
            return w - 32'h57;
        end
    endfunction

    // UTF-8 encoding of a code point, replacement character when zero or above 0x10ffff
    function automatic t_job encode_cp(input logic [31:0] cp);
        t_job j;
        j = '0;
        if (cp == 32'd0 || cp > CP_MAX) begin
            j.bytes[0] = REPL_B0;
            j.bytes[1] = REPL_B1;
            j.bytes[2] = REPL_B2;
            j.last_idx = 2'd2;
        end else if (cp <= CP_MAX_1B) begin
            j.bytes[0] = cp[7:0];
            j.last_idx = 2'd0;
        end else if (cp <= CP_MAX_2B) begin
            j.bytes[0] = LEAD_2B | {3'd0, cp[10:6]};
            j.bytes[1] = CONT_BYTE | {2'd0, cp[5:0]};
            j.last_idx = 2'd1;
        end else if (cp <= CP_MAX_3B) begin
            j.bytes[0] = LEAD_3B | {4'd0, cp[15:12]};
            j.bytes[1] = CONT_BYTE | {2'd0, cp[11:6]};
            j.bytes[2] = CONT_BYTE | {2'd0, cp[5:0]};
            j.last_idx = 2'd2;
        end else begin
            j.bytes[0] = LEAD_4B | {5'd0, cp[20:18]};
            j.bytes[1] = CONT_BYTE | {2'd0, cp[17:12]};
            j.bytes[2] = CONT_BYTE | {2'd0, cp[11:6]};
            j.bytes[3] = CONT_BYTE | {2'd0, cp[5:0]};
            j.last_idx = 2'd3;
        end
        return j;
    endfunction

endpackage

### rtl/neu8_front.sv
// Front end: accepts token bytes, tracks token state and builds output jobs.
module neu8_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  neu8_pkg::t_in    i_item,
    input  logic             i_full,
    output logic             o_push,
    output neu8_pkg::t_job   o_job
);
    import neu8_pkg::*;

    logic [1:0]      r_pos, n_pos;
    logic            r_echo, n_echo;
    logic [31:0]     r_hex, n_hex;
    logic [31:0]     r_dec, n_dec;
    logic [2:0][7:0] r_held, n_held;

    logic        accept;
    logic [7:0]  b;
    logic        eot;
    logic [31:0] dec_step;
    logic [31:0] hex_step;
    logic        is_hex;

    assign accept   = i_valid && !i_full;
    assign b        = i_item.token_byte;
    assign eot      = i_item.token_end;
    assign dec_step = (r_dec << 3) + (r_dec << 1) + ({24'd0, b} - {24'd0, CH_ZERO});
    assign hex_step = (r_hex << 4) + hex_digit(b);
    assign is_hex   = (r_held[2] == CH_LOWER_X) || (r_held[2] == CH_UPPER_X);

    // Classify the byte and build the job it causes
    always_comb begin
        n_pos  = r_pos;
        n_echo = r_echo;
        n_hex  = r_hex;
        n_dec  = r_dec;
        n_held = r_held;
        o_push = 1'b0;
        o_job  = '0;
        if (accept) begin
            if (r_echo) begin
                o_push         = 1'b1;
                o_job.bytes[0] = b;
            end else begin
                unique case (r_pos)
                    2'd0: begin
                        n_held[0]      = b;
                        o_push         = eot;
                        o_job.bytes[0] = b;
                    end
                    2'd1: begin
                        n_held[1] = b;
                        if (b != CH_HASH || eot) begin
                            o_push         = 1'b1;
                            o_job.bytes[0] = r_held[0];
                            o_job.bytes[1] = b;
                            o_job.last_idx = 2'd1;
                            if (!eot) begin
                                n_echo = 1'b1;
                            end
                        end
                    end
                    2'd2: begin
                        n_held[2] = b;
                        if (eot) begin
                            o_push         = 1'b1;
                            o_job.bytes[0] = r_held[0];
                            o_job.bytes[1] = r_held[1];
                            o_job.bytes[2] = b;
                            o_job.last_idx = 2'd2;
                        end else begin
                            n_dec = dec_step;
                        end
                    end
                    default: begin
                        if (eot) begin
                            o_push = 1'b1;
                            o_job  = encode_cp(is_hex ? r_hex : r_dec);
                        end else begin
                            n_dec = dec_step;
                            n_hex = hex_step;
                        end
                    end
                endcase
            end
            // Terminator starts a new token
            if (eot) begin
                n_pos  = 2'd0;
                n_echo = 1'b0;
                n_hex  = '0;
                n_dec  = '0;
            end else if (r_pos != 2'd3) begin
                n_pos = r_pos + 2'd1;
            end
        end
    end

    // Hold token state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_echo <= 1'b0;
            r_hex  <= '0;
            r_dec  <= '0;
        end else begin
            r_pos  <= n_pos;
            r_echo <= n_echo;
            r_hex  <= n_hex;
            r_dec  <= n_dec;
        end
    end

    // Hold the first token bytes
    always_ff @(posedge i_clk) begin
        r_held <= n_held;
    end

endmodule

### rtl/neu8_queue.sv
// Job queue between the front end and the byte serializer.
module neu8_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  neu8_pkg::t_job   i_job,
    input  logic             i_pop,
    output neu8_pkg::t_job   o_job,
    output logic             o_empty,
    output logic             o_full
);
    import neu8_pkg::*;

    t_job                 r_mem [NEU8_QDEPTH];
    logic [NEU8_QPTR_W-1:0] r_wr, n_wr;
    logic [NEU8_QPTR_W-1:0] r_rd, n_rd;
    logic [NEU8_QPTR_W:0]   r_cnt, n_cnt;
    logic                 do_push;
    logic                 do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (NEU8_QPTR_W+1)'(NEU8_QDEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd];

    // Advance pointers and count
    always_comb begin
        n_wr  = do_push ? r_wr + (NEU8_QPTR_W)'(1) : r_wr;
        n_rd  = do_pop ? r_rd + (NEU8_QPTR_W)'(1) : r_rd;
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + (NEU8_QPTR_W+1)'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - (NEU8_QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Store the pushed job
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

### rtl/neu8_back.sv
// Back end: serializes queued jobs into output beats.
module neu8_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  neu8_pkg::t_job   i_job,
    input  logic             i_empty,
    output logic             o_pop,
    output logic             o_valid,
    output neu8_pkg::t_out   o_res,
    input  logic             i_stall
);
    import neu8_pkg::*;

    logic       r_busy, n_busy;
    logic [1:0] r_idx, n_idx;
    t_job       r_job, n_job;
    logic       fire;
    logic       is_last;

    assign is_last        = (r_idx == r_job.last_idx);
    assign fire           = r_busy && !i_stall;
    assign o_pop          = !i_empty && (!r_busy || (fire && is_last));
    assign o_valid        = r_busy;
    assign o_res.out_byte = r_job.bytes[r_idx];
    assign o_res.run_end  = is_last;

    // Step through the current job, load the next one after its last beat
    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        n_job  = r_job;
        if (o_pop) begin
            n_busy = 1'b1;
            n_idx  = '0;
            n_job  = i_job;
        end else if (fire) begin
            if (is_last) begin
                n_busy = 1'b0;
            end else begin
                n_idx = r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

    // Hold the job payload
    always_ff @(posedge i_clk) begin
        r_job <= n_job;
    end

endmodule

### rtl/numeric_entity_to_utf8.sv
// Path: the job an accepted input beat completes is registered in the job queue,
// then in the back end's job register. Throughput: one input beat per cycle while
// the job queue is not full; one output byte per cycle while i_res_stall is low, so
// a multi-byte job holds the output side, absorbed by the four-entry job queue.
// Reset: synchronous active-low i_rst_n clears token state, queue and output valid.
module numeric_entity_to_utf8 (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_item_valid,
    input  neu8_pkg::t_in    i_item,
    output logic             o_item_stall,
    output logic             o_res_valid,
    output neu8_pkg::t_out   o_res,
    input  logic             i_res_stall
);
    import neu8_pkg::*;

    logic full;
    logic empty;
    logic push;
    logic pop;
    t_job push_job;
    t_job head_job;

    assign o_item_stall = full;

    // Accept and classify token bytes
    neu8_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_item_valid),
        .i_item  (i_item),
        .i_full  (full),
        .o_push  (push),
        .o_job   (push_job)
    );

    // Decouple front and back
    neu8_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_empty (empty),
        .o_full  (full)
    );

    // Serialize jobs to output beats
    neu8_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (head_job),
        .i_empty (empty),
        .o_pop   (pop),
        .o_valid (o_res_valid),
        .o_res   (o_res),
        .i_stall (i_res_stall)
    );

endmodule

### tb/numeric_entity_to_utf8_tb.sv
// Self-checking testbench for numeric_entity_to_utf8: entity tokens in, UTF-8 bytes compared out.
module numeric_entity_to_utf8_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import neu8_pkg::*;

    localparam int RANDOM_BEATS   = 380;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 20;

    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_SEMI = 8'h3b;

    // Idle mixes, one per run phase
    localparam logic [1:0] PH_SLOW_RX = 2'd0;
    localparam logic [1:0] PH_SLOW_TX = 2'd1;
    localparam logic [1:0] PH_FULL    = 2'd2;
    localparam logic [1:0] PH_NONE    = 2'd3;

    // Code points that sit on the encoding boundaries
    localparam logic [31:0] LIMIT_POINTS [14] = '{
        32'h0, 32'h1, 32'h7f, 32'h80, 32'h7ff, 32'h800, 32'hd7ff, 32'hd800,
        32'hdfff, 32'hffff, 32'h10000, 32'h10ffff, 32'h110000, 32'hffffffff
    };

    typedef logic [7:0] t_byte_q [$];

    typedef struct {
        t_in        beat;
        logic [1:0] phase;
        bit         drain;
    } t_token_beat;

    logic i_clk        = 1'b0;
    logic i_rst_n      = 1'b0;
    logic i_item_valid = 1'b0;
    t_in  i_item       = '0;
    logic o_item_stall;
    logic o_res_valid;
    t_out o_res;
    logic i_res_stall  = 1'b0;

    numeric_entity_to_utf8 dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_item_valid),
        .i_item       (i_item),
        .o_item_stall (o_item_stall),
        .o_res_valid  (o_res_valid),
        .o_res        (o_res),
        .i_res_stall  (i_res_stall)
    );

    // Stimulus and expectations
    t_token_beat token_beats [$];
    t_out        owed_bytes [$];
    t_byte_q     tok_buf;
    logic [1:0]  rx_phase;

    // Decoder state of the predictor
    logic [1:0]  tok_pos;
    logic [7:0]  tok_head [3];
    logic [31:0] hex_acc;
    logic [31:0] dec_acc;
    logic        echo_on;

    int results_predicted = 0;
    int results_checked   = 0;
    int beats_sent        = 0;
    int n_errors          = 0;
    int quiet_cycles      = 0;
    int n_numeric = 0, n_hex = 0, n_lax = 0, n_echo = 0, n_short = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Percent of cycles a side idles in a given phase
    function automatic int idle_pct(input logic [1:0] phase, input bit sender);
        case (phase)
            PH_SLOW_RX: return sender ? 33 : 55;
            PH_SLOW_TX: return sender ? 55 : 33;
            default:    return 0;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        n_errors++;
        $display("%0t ns: result %0d: %s: got %0h, want %0h", $time, results_checked, what,
                 got, want);
    endtask

    // Move the built token into the beat queue, terminator flagged on the last byte
    task automatic flush_token(input logic [1:0] phase, input bit drain);
        t_token_beat tb_beat;
        for (int i = 0; i < tok_buf.size(); i++) begin
            tb_beat.beat.token_byte = tok_buf[i];
            tb_beat.beat.token_end  = (i == tok_buf.size() - 1);
            tb_beat.phase           = phase;
            tb_beat.drain           = drain && (i == 0);
            token_beats.push_back(tb_beat);
        end
        tok_buf.delete();
    endtask

    // Advance the decoder by one accepted beat and queue the bytes it owes
    task automatic decode_entity_beat(input t_in beat);
        t_byte_q     run;
        logic [7:0]  b;
        logic [31:0] cp;
        logic [31:0] digit;
        t_out        r;
        b = beat.token_byte;
        if (echo_on) begin
            run.push_back(b);
        end else begin
            case (tok_pos)
                2'd0: begin
                    tok_head[0] = b;
                    if (beat.token_end) run.push_back(b);
                end
                2'd1: begin
                    tok_head[1] = b;
                    if (b != CH_HASH || beat.token_end) begin
                        run.push_back(tok_head[0]);
                        run.push_back(b);
                        if (!beat.token_end) echo_on = 1'b1;
                    end
                end
                2'd2: begin
                    tok_head[2] = b;
                    if (beat.token_end) begin
                        run = '{tok_head[0], tok_head[1], b};
                    end else begin
                        dec_acc = dec_acc * 32'd10 + ({24'd0, b} - 32'h30);
                    end
                end
                default: begin
                    if (beat.token_end) begin
                        cp = (tok_head[2] == CH_LOWER_X || tok_head[2] == CH_UPPER_X) ?
                             hex_acc : dec_acc;
                        if (cp == 32'd0 || cp > CP_MAX) begin
                            run = '{REPL_B0, REPL_B1, REPL_B2};
                        end else if (cp <= CP_MAX_1B) begin
                            run = '{cp[7:0]};
                        end else if (cp <= CP_MAX_2B) begin
                            run = '{8'hc0 | {3'd0, cp[10:6]}, 8'h80 | {2'd0, cp[5:0]}};
                        end else if (cp <= CP_MAX_3B) begin
                            run = '{8'he0 | {4'd0, cp[15:12]}, 8'h80 | {2'd0, cp[11:6]},
                                    8'h80 | {2'd0, cp[5:0]}};
                        end else begin
                            run = '{8'hf0 | {5'd0, cp[20:18]}, 8'h80 | {2'd0, cp[17:12]},
                                    8'h80 | {2'd0, cp[11:6]}, 8'h80 | {2'd0, cp[5:0]}};
                        end
                    end else begin
                        // Both accumulators run; the third byte picks one at the end
                        dec_acc = dec_acc * 32'd10 + ({24'd0, b} - 32'h30);
                        if (b >= CH_ZERO && b <= CH_NINE) begin
                            digit = {24'd0, b} - 32'h30;
                        end else if (b >= CH_UPPER_A && b <= CH_UPPER_Z) begin
                            digit = {24'd0, b} - 32'h41 + 32'd10;
                        end else begin
                            digit = {24'd0, b} - 32'h61 + 32'd10;
                        end
                        hex_acc = {hex_acc[27:0], 4'd0} + digit;
                    end
                end
            endcase
        end

        for (int i = 0; i < run.size(); i++) begin
            r.out_byte = run[i];
            r.run_end  = (i == run.size() - 1);
            owed_bytes.push_back(r);
            results_predicted++;
        end

        // Terminator starts a new token
        if (beat.token_end) begin
            tok_pos = 2'd0;
            echo_on = 1'b0;
            hex_acc = '0;
            dec_acc = '0;
        end else if (tok_pos != 2'd3) begin
            tok_pos = tok_pos + 2'd1;
        end
    endtask

    // Driver: predict accepted beats, hold stalled ones, offer the next
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_item_valid <= 1'b0;
            i_item       <= '0;
            rx_phase     <= PH_SLOW_RX;
            tok_pos = 2'd0;
            tok_head = '{8'd0, 8'd0, 8'd0};
            hex_acc = '0;
            dec_acc = '0;
            echo_on = 1'b0;
        end else begin
            if (i_item_valid && !o_item_stall) begin
                decode_entity_beat(i_item);
                beats_sent++;
            end
            if (!(i_item_valid && o_item_stall)) begin
                if (token_beats.size() != 0
                        && !(token_beats[0].drain && results_predicted != results_checked)
                        && $urandom_range(0, 99) >= idle_pct(token_beats[0].phase, 1'b1)) begin
                    i_item_valid <= 1'b1;
                    i_item       <= token_beats[0].beat;
                    rx_phase     <= token_beats[0].phase;
                    void'(token_beats.pop_front());
                end else begin
                    i_item_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each accepted result beat with the oldest owed byte
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            i_res_stall <= 1'b0;
        end else begin
            if (o_res_valid && !i_res_stall) begin
                if (owed_bytes.size() == 0) begin
                    report_mismatch("beat with nothing owed", int'(o_res.out_byte), 0);
                end else begin
                    want = owed_bytes.pop_front();
                    if (o_res.out_byte !== want.out_byte)
                        report_mismatch("out_byte", int'(o_res.out_byte),
                                        int'(want.out_byte));
                    if (o_res.run_end !== want.run_end)
                        report_mismatch("run_end", int'(o_res.run_end), int'(want.run_end));
                    results_checked <= results_checked + 1;
                end
            end
            i_res_stall <= ($urandom_range(0, 99) < idle_pct(rx_phase, 1'b0));
        end
    end

    // Watchdog: end the run when no beat moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((i_item_valid && !o_item_stall) || (o_res_valid && !i_res_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles, %0d bytes still owed",
                     quiet_cycles, owed_bytes.size());
            $display("** numeric_entity_to_utf8: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [1:0]      ph;
        logic [1:0]      last_ph;
        bit              drain;
        int              kind;
        int              random_beats;
        int              nd;
        int              len;
        logic [31:0]     cp;
        logic [3:0]      nib;
        longint unsigned v;
        t_byte_q         digs;

        // Directed tokens: short ones, echo, zero, empty hex, lax digits
        tok_buf = '{8'h00};
        flush_token(PH_SLOW_RX, 1'b0);
        tok_buf = '{CH_AMP, CH_HASH};
        flush_token(PH_SLOW_RX, 1'b0);
        tok_buf = '{CH_AMP, CH_HASH, CH_SEMI};
        flush_token(PH_SLOW_RX, 1'b0);
        tok_buf = '{CH_AMP, 8'h62, 8'hff};
        flush_token(PH_SLOW_RX, 1'b0);
        tok_buf = '{CH_AMP, CH_HASH, CH_ZERO, CH_SEMI};
        flush_token(PH_SLOW_RX, 1'b0);
        tok_buf = '{CH_AMP, CH_HASH, CH_LOWER_X, CH_SEMI};
        flush_token(PH_SLOW_RX, 1'b0);
        tok_buf = '{CH_AMP, CH_HASH, CH_UPPER_X, CH_UPPER_Z, CH_SEMI};
        flush_token(PH_SLOW_RX, 1'b0);
        tok_buf = '{CH_AMP, CH_HASH, 8'hff, CH_SEMI};
        flush_token(PH_SLOW_RX, 1'b0);

        // Random tokens, mostly well-formed references, split over three idle mixes
        random_beats = 0;
        last_ph = PH_NONE;
        while (random_beats < RANDOM_BEATS) begin
            ph = 2'(random_beats * 3 / RANDOM_BEATS);
            drain = (ph != last_ph) || ($urandom_range(0, 39) == 0);
            last_ph = ph;
            kind = $urandom_range(0, 99);
            if (kind < 60) begin
                // Well-formed reference of a code point from one size class
                case ($urandom_range(0, 6))
                    0: cp = $urandom_range(1, 32'h7f);
                    1: cp = $urandom_range(32'h80, 32'h7ff);
                    2: cp = $urandom_range(32'h800, 32'hffff);
                    3: cp = $urandom_range(32'hd800, 32'hdfff);
                    4: cp = $urandom_range(32'h10000, 32'h10ffff);
                    5: cp = $urandom | 32'h0020_0000;
                    default: cp = LIMIT_POINTS[$urandom_range(0, 13)];
                endcase
                tok_buf.push_back(($urandom_range(0, 9) != 0) ? CH_AMP : 8'($urandom));
                tok_buf.push_back(CH_HASH);
                n_numeric++;
                if ($urandom_range(0, 1) != 0) begin
                    n_hex++;
                    tok_buf.push_back(($urandom_range(0, 1) != 0) ? CH_LOWER_X : CH_UPPER_X);
                    repeat ($urandom_range(0, 2)) tok_buf.push_back(CH_ZERO);
                    nd = 8;
                    while (nd > 1 && cp[4*nd-1 -: 4] == 4'd0) nd--;
                    for (int i = nd - 1; i >= 0; i--) begin
                        nib = cp[4*i +: 4];
                        if (nib < 4'd10)
                            tok_buf.push_back(CH_ZERO + {4'd0, nib});
                        else
                            tok_buf.push_back((($urandom_range(0, 1) != 0) ? 8'h41 : 8'h61)
                                              + {4'd0, nib} - 8'd10);
                    end
                end else begin
                    repeat ($urandom_range(0, 1)) tok_buf.push_back(CH_ZERO);
                    v = cp;
                    digs.delete();
                    do begin
                        digs.push_front(CH_ZERO + 8'(v % 10));
                        v = v / 10;
                    end while (v != 0);
                    foreach (digs[i]) tok_buf.push_back(digs[i]);
                end
                tok_buf.push_back(($urandom_range(0, 6) != 0) ? CH_SEMI : 8'($urandom));
            end else if (kind < 75) begin
                // Numeric prefix with arbitrary digit bytes
                n_lax++;
                tok_buf.push_back(CH_AMP);
                tok_buf.push_back(CH_HASH);
                if ($urandom_range(0, 1) != 0)
                    tok_buf.push_back(($urandom_range(0, 1) != 0) ? CH_LOWER_X : CH_UPPER_X);
                else
                    tok_buf.push_back(8'($urandom));
                repeat ($urandom_range(0, 5)) tok_buf.push_back(8'($urandom));
                tok_buf.push_back(8'($urandom));
            end else if (kind < 90) begin
                // Named entity or garbage: echoed once the second byte is seen
                n_echo++;
                tok_buf.push_back(($urandom_range(0, 1) != 0) ? CH_AMP : 8'($urandom));
                tok_buf.push_back(8'($urandom));
                if (tok_buf[1] == CH_HASH) tok_buf[1] = tok_buf[1] ^ 8'h01;
                repeat ($urandom_range(0, 6)) tok_buf.push_back(8'($urandom));
                tok_buf.push_back(8'($urandom));
            end else begin
                // Token of one to three bytes
                n_short++;
                len = $urandom_range(1, 3);
                tok_buf.push_back(($urandom_range(0, 1) != 0) ? CH_AMP : 8'($urandom));
                if (len > 1)
                    tok_buf.push_back(($urandom_range(0, 1) != 0) ? CH_HASH : 8'($urandom));
                if (len > 2)
                    tok_buf.push_back(8'($urandom));
            end
            random_beats += tok_buf.size();
            flush_token(ph, drain);
        end

        // Release reset
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every beat to go in and every owed byte to come out
        do begin
            @(negedge i_clk);
        end while (token_beats.size() != 0 || i_item_valid
                   || results_checked != results_predicted);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (owed_bytes.size() != 0)
            report_mismatch("bytes still owed at end", 0, owed_bytes.size());

        $display("sent %0d beats: %0d numeric references (%0d hex), %0d lax, %0d echoed, %0d short",
                 beats_sent, n_numeric, n_hex, n_lax, n_echo, n_short);
        $display("checked %0d result beats over three stall mixes, %0d mismatches",
                 results_checked, n_errors);
        if (n_errors == 0) begin
            $display("** numeric_entity_to_utf8: PASSED **");
        end else begin
            $display("** numeric_entity_to_utf8: FAILED **");
        end
        $finish;
    end

endmodule
